// ===== rtl/fac_pkg.sv =====
`default_nettype none
package fac_pkg;

    localparam int ENTRIES = 16;
    localparam int ADDR_W  = 16;
    localparam int WORD_W  = 32;
    localparam int CTR_W   = 32;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    localparam int S_TDATA_W = ((ADDR_W + WORD_W + 7) / 8) * 8;
    localparam int M_FIELD_W = IDX_W + WORD_W + 2 * CTR_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] slot;
    } lookup_t;

endpackage
`default_nettype wire

// ===== rtl/fac_word_ram.sv =====
`default_nettype none
module fac_word_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  wire logic                                   aclk,
    input  wire logic                                   we,
    input  wire logic                                   re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  wire logic [WIDTH-1:0]                       wdata,
    output logic      [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[addr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/fac_tag_cam.sv =====
`default_nettype none
module fac_tag_cam (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      lookup_en,
    input  wire logic                      kind,
    input  wire logic [fac_pkg::ADDR_W-1:0] address,
    output fac_pkg::lookup_t               result
);
    import fac_pkg::*;

    logic              tag_kind [ENTRIES];
    logic [ADDR_W-1:0] tag_addr [ENTRIES];

    logic [CNT_W-1:0] filled_reg, filled_next;
    logic [IDX_W-1:0] oldest_reg, oldest_next;

    logic [ENTRIES-1:0] match;
    logic               any_hit;
    logic [IDX_W-1:0]   hit_idx;
    logic               full;
    logic [IDX_W-1:0]   victim;

    // only filled entries take part; unwritten tags never match
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = (CNT_W'(i) < filled_reg) && (tag_kind[i] == kind)
                       && (tag_addr[i] == address);
        end
    end

    // lowest matching index wins
    always_comb begin
        hit_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_idx = IDX_W'(i);
            end
        end
    end

    assign any_hit = |match;
    assign full    = (filled_reg == CNT_W'(ENTRIES));
    assign victim  = full ? oldest_reg : filled_reg[IDX_W-1:0];

    always_comb begin
        filled_next = filled_reg;
        oldest_next = oldest_reg;
        if (lookup_en && !any_hit) begin
            if (!full) begin
                filled_next = filled_reg + CNT_W'(1);
            end else if (oldest_reg == IDX_W'(ENTRIES - 1)) begin
                oldest_next = '0;
            end else begin
                oldest_next = oldest_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filled_reg <= '0;
            oldest_reg <= '0;
        end else begin
            filled_reg <= filled_next;
            oldest_reg <= oldest_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (lookup_en && !any_hit) begin
            tag_kind[victim] <= kind;
            tag_addr[victim] <= address;
        end
    end

    assign result.hit  = any_hit;
    assign result.slot = any_hit ? hit_idx : victim;
endmodule
`default_nettype wire

// ===== rtl/fully_assoc_fifo_cache.sv =====
// Fully associative read cache, FIFO replacement.
// Input channel s_*: one beat per request. s_tuser is the access kind
// (0 instruction, 1 data); s_tdata carries the word address and the
// backing-memory word, which is stored only on a miss.
// Output channel m_*: one beat per request, in request order. m_tuser is
// the hit flag; m_tdata carries slot, returned word and the running hit
// and miss counts including this request.
// An accepted request moves through the lookup stage and the read stage
// into the output register, one request at a time: the tag compare
// runs in the cycle after accept, the data RAM read or fill in the same
// cycle, and the next request is taken once the RAM data has moved on.
// A result waiting on m_* does not block the next request; if the
// receiver stalls longer, the one request behind it holds in the read
// stage and s_tready stays low.
// Reset (aresetn low, synchronous) empties the cache and clears the
// counters; stored tags and words are not cleared and are never read
// before they are written.
`default_nettype none
module fully_assoc_fifo_cache (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [ADDR_W-1:0] address, then fill_word, zero padded
    input  wire logic [fac_pkg::S_TDATA_W-1:0] s_tdata,
    // kind
    input  wire logic                          s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // slot, read_word, hits_so_far, misses_so_far, zero padded
    output logic      [fac_pkg::M_TDATA_W-1:0] m_tdata,
    // hit
    output logic                               m_tuser
);
    import fac_pkg::*;

    logic              req_valid_reg;
    logic              req_kind_reg;
    logic [ADDR_W-1:0] req_addr_reg;
    logic [WORD_W-1:0] req_word_reg;

    logic              b_valid_reg;
    logic              b_hit_reg;
    logic [IDX_W-1:0]  b_slot_reg;
    logic [WORD_W-1:0] b_word_reg;

    logic [CTR_W-1:0] hits_reg, hits_next;
    logic [CTR_W-1:0] misses_reg, misses_next;

    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic                 m_hit_reg;

    lookup_t           look;
    logic [WORD_W-1:0] ram_q;
    logic              s_fire;
    logic              out_free;
    logic [WORD_W-1:0] ret_word;

    assign s_tready = !req_valid_reg && !b_valid_reg;
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    fac_tag_cam u_cam (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .lookup_en (req_valid_reg),
        .kind      (req_kind_reg),
        .address   (req_addr_reg),
        .result    (look)
    );

    fac_word_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (WORD_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (req_valid_reg && !look.hit),
        .re    (req_valid_reg && look.hit),
        .addr  (look.slot),
        .wdata (req_word_reg),
        .rdata (ram_q)
    );

    always_comb begin
        hits_next   = hits_reg;
        misses_next = misses_reg;
        if (req_valid_reg) begin
            if (look.hit) begin
                hits_next = hits_reg + CTR_W'(1);
            end else begin
                misses_next = misses_reg + CTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
            b_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            hits_reg      <= '0;
            misses_reg    <= '0;
        end else begin
            req_valid_reg <= s_fire;
            if (req_valid_reg) begin
                b_valid_reg <= 1'b1;
            end else if (b_valid_reg && out_free) begin
                b_valid_reg <= 1'b0;
            end
            if (b_valid_reg && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            hits_reg   <= hits_next;
            misses_reg <= misses_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            req_kind_reg <= s_tuser;
            req_addr_reg <= s_tdata[ADDR_W-1:0];
            req_word_reg <= s_tdata[ADDR_W+WORD_W-1:ADDR_W];
        end
        if (req_valid_reg) begin
            b_hit_reg  <= look.hit;
            b_slot_reg <= look.slot;
            b_word_reg <= req_word_reg;
        end
    end

    assign ret_word = b_hit_reg ? ram_q : b_word_reg;

    // counters are stable while a request sits in the read stage
    always_ff @(posedge aclk) begin
        if (b_valid_reg && out_free) begin
            m_hit_reg  <= b_hit_reg;
            m_data_reg <= M_TDATA_W'({misses_reg, hits_reg, ret_word, b_slot_reg});
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_hit_reg;

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        !(req_valid_reg && b_valid_reg))
        else $error("lookup and read stage busy at once");

    a_accept_to_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> req_valid_reg && !s_tready)
        else $error("accepted request did not enter lookup");

    // RAM data only matters for a hit; on a miss it may never have been read
    a_read_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && !out_free) |=> (b_valid_reg && $stable(b_slot_reg)
                                        && (!b_hit_reg || $stable(ram_q))))
        else $error("read stage lost data while output stalled");

    a_lookup_to_read: assert property (@(posedge aclk) disable iff (!aresetn)
        req_valid_reg |=> b_valid_reg)
        else $error("lookup result not captured");
endmodule
`default_nettype wire

// ===== verif/fac_result_checker.sv =====
module fac_result_checker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    // [ADDR_W-1:0] address, then fill_word
    input  wire logic [fac_pkg::S_TDATA_W-1:0] s_tdata,
    // kind
    input  wire logic                          s_tuser,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    // slot, read_word, hits_so_far, misses_so_far, zero padded
    input  wire logic [fac_pkg::M_TDATA_W-1:0] m_tdata,
    // hit
    input  wire logic                          m_tuser,
    output int unsigned                        error_count,
    output int unsigned                        outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import fac_pkg::*;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] slot;
        logic [WORD_W-1:0] read_word;
        logic [CTR_W-1:0] hits;
        logic [CTR_W-1:0] misses;
    } cache_reply_t;

    // shadow copy of the cache contents
    logic              tag_kind  [ENTRIES];
    logic [ADDR_W-1:0] tag_addr  [ENTRIES];
    logic [WORD_W-1:0] line_word [ENTRIES];
    int unsigned       filled;
    int unsigned       oldest;
    logic [CTR_W-1:0]  hit_total;
    logic [CTR_W-1:0]  miss_total;

    cache_reply_t expected_replies[$];

    task automatic predict_access(input logic kind, input logic [ADDR_W-1:0] addr,
                                  input logic [WORD_W-1:0] word,
                                  output cache_reply_t reply);
        int unsigned idx;
        bit          found;
        found = 1'b0;
        idx   = 0;
        // only filled entries take part in the compare
        for (int unsigned i = 0; i < filled; i++) begin
            if (!found && tag_kind[i] == kind && tag_addr[i] == addr) begin
                found = 1'b1;
                idx   = i;
            end
        end
        if (found) begin
            hit_total       = hit_total + 1'b1;
            reply.read_word = line_word[idx];
        end else begin
            miss_total = miss_total + 1'b1;
            if (filled < ENTRIES) begin
                idx    = filled;
                filled = filled + 1;
            end else begin
                idx    = oldest;
                oldest = (oldest + 1) % ENTRIES;
            end
            tag_kind[idx]   = kind;
            tag_addr[idx]   = addr;
            line_word[idx]  = word;
            reply.read_word = word;
        end
        reply.hit    = found;
        reply.slot   = IDX_W'(idx);
        reply.hits   = hit_total;
        reply.misses = miss_total;
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: %s mismatch: got %0h, expected %0h", $time, what, got, want);
        error_count = error_count + 1;
    endtask

    always @(posedge aclk) begin
        cache_reply_t reply;
        cache_reply_t want;
        if (!aresetn) begin
            filled      = 0;
            oldest      = 0;
            hit_total   = '0;
            miss_total  = '0;
            error_count = 0;
            expected_replies.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                predict_access(s_tuser, s_tdata[ADDR_W-1:0], s_tdata[ADDR_W +: WORD_W], reply);
                expected_replies.insert(expected_replies.size(), reply);
            end
            if (m_tvalid && m_tready) begin
                if (expected_replies.size() == 0) begin
                    report_mismatch("unrequested result beat", 64'(m_tuser), 64'd0);
                end else begin
                    want = expected_replies.pop_front();
                    if (m_tuser !== want.hit)
                        report_mismatch("hit", 64'(m_tuser), 64'(want.hit));
                    if (m_tdata[IDX_W-1:0] !== want.slot)
                        report_mismatch("slot", 64'(m_tdata[IDX_W-1:0]), 64'(want.slot));
                    if (m_tdata[IDX_W +: WORD_W] !== want.read_word)
                        report_mismatch("read_word", 64'(m_tdata[IDX_W +: WORD_W]),
                                        64'(want.read_word));
                    if (m_tdata[IDX_W+WORD_W +: CTR_W] !== want.hits)
                        report_mismatch("hits_so_far", 64'(m_tdata[IDX_W+WORD_W +: CTR_W]),
                                        64'(want.hits));
                    if (m_tdata[IDX_W+WORD_W+CTR_W +: CTR_W] !== want.misses)
                        report_mismatch("misses_so_far",
                                        64'(m_tdata[IDX_W+WORD_W+CTR_W +: CTR_W]),
                                        64'(want.misses));
                end
            end
        end
        outstanding = expected_replies.size();
    end

endmodule

// ===== verif/fully_assoc_fifo_cache_tb.sv =====
module fully_assoc_fifo_cache_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fac_pkg::*;

    localparam int IDLE_LIMIT   = 1000;
    localparam int HOLD_CYCLES  = 80;
    localparam int PHASE_ITEMS  = 410;
    localparam int POOL_SIZE    = 12;
    localparam logic KIND_INSTR = 1'b0;
    localparam logic KIND_DATA  = 1'b1;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    int unsigned error_count;
    int unsigned outstanding;

    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_off_req;
    int unsigned quiet_cycles;

    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

    fully_assoc_fifo_cache DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    fac_result_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(negedge aclk) begin
        if (hold_off_req) begin
            m_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge aclk);
            hold_off_req = 1'b0;
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on beats in either direction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(input logic kind, input logic [ADDR_W-1:0] addr,
                                input logic [WORD_W-1:0] word);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= S_TDATA_W'({word, addr});
        do @(posedge aclk); while (!s_tready);
    endtask

    // mostly tags from a small pool so that hits and evictions are frequent
    task automatic send_random_request();
        if ($urandom_range(99) < 75)
            send_request(logic'($urandom_range(1)), addr_pool[$urandom_range(POOL_SIZE-1)],
                         WORD_W'($urandom));
        else
            send_request(logic'($urandom_range(1)), ADDR_W'($urandom), WORD_W'($urandom));
    endtask

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tuser        = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_req   = 1'b0;
        quiet_cycles   = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: field extremes, same address under both kinds
        send_request(KIND_INSTR, '0, '0);
        send_request(KIND_DATA, '0, '1);
        send_request(KIND_INSTR, '1, 32'hA5A5_A5A5);
        send_request(KIND_DATA, '1, 32'h5A5A_5A5A);
        send_request(KIND_INSTR, '0, 32'hDEAD_BEEF);   // hit, stored word wins
        send_request(KIND_DATA, '1, 32'h1234_5678);
        // fill remaining entries, then replace oldest in order
        for (int i = 0; i < 12; i++)
            send_request(logic'(i % 2), ADDR_W'(16'h1000 + i), WORD_W'($urandom));
        send_request(KIND_INSTR, 16'h2000, 32'h0BAD_F00D);  // evicts slot 0
        send_request(KIND_INSTR, '0, 32'hCAFE_0001);        // evicted tag misses again
        send_request(KIND_DATA, '1, 32'h0);                  // still resident
        send_request(KIND_INSTR, 16'h2000, 32'h0);           // hit on fresh fill
        send_request(KIND_DATA, 16'h1003, 32'h0);            // hit in middle slot

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            for (int j = 0; j < POOL_SIZE; j++)
                addr_pool[j] = ADDR_W'($urandom);
            if (phase == 0)
                hold_off_req = 1'b1;   // back up the result side while requests keep coming
            repeat (PHASE_ITEMS) send_random_request();
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (outstanding == 0);
        repeat (8) @(posedge aclk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
